// ===== design/tac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the touch averaging and calibration block.
// Used by every module in this folder; depends on nothing.
package tac_pkg;

  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned CAL_W           = 12;
  localparam int unsigned SIZE_W          = 11;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned SUM_W           = 15;
  // |avg - min| * size: 12 bits times 11 bits
  localparam int unsigned PROD_W          = CAL_W + SIZE_W;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 12;
  localparam int unsigned FRAME_LEN_DEF   = 8;

  localparam logic [CAL_W-1:0]  CAL_LEFT_RST   = 12'd0;
  localparam logic [CAL_W-1:0]  CAL_RIGHT_RST  = 12'd4095;
  localparam logic [CAL_W-1:0]  CAL_BOTTOM_RST = 12'd0;
  localparam logic [CAL_W-1:0]  CAL_TOP_RST    = 12'd4095;
  localparam logic [SIZE_W-1:0] WIDTH_RST      = 11'd480;
  localparam logic [SIZE_W-1:0] HEIGHT_RST     = 11'd272;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_LEFT   = 3'd0,
    CFG_CAL_RIGHT  = 3'd1,
    CFG_CAL_BOTTOM = 3'd2,
    CFG_CAL_TOP    = 3'd3,
    CFG_WIDTH      = 3'd4,
    CFG_HEIGHT     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_MAP_START,
    ST_MAP_WAIT,
    ST_OUT
  } state_e;

  localparam logic AXIS_H = 1'b0;
  localparam logic AXIS_V = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                axis;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      cal_error;
  } out_beat_t;

  typedef struct packed {
    logic accumulate;
    logic axis;
    logic div_start;
    logic lat_avg;
    logic mul_en;
    logic lat_coord;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic div_done;
  } ctrl_sts_t;

endpackage

// ===== design/touch_average_calibrate.sv =====
`timescale 1ns / 1ps
// Touch sample averaging and linear screen calibration. Each input beat is one
// 12-bit ADC sample tagged with its axis; samples for an axis that already holds
// FRAME_LEN are taken and dropped. Once both axes hold FRAME_LEN samples,
// input stalls: each axis forms its average by reciprocal multiplication, then
// one shared divider, producing one quotient bit per cycle, runs a 23-bit
// mapping division. Input is ready again from the cycle in which the result
// beat is presented. If the previous result is still untaken when the new one
// is ready, input stays stalled until that beat is taken. A result waiting in
// the output register does not block sampling of the next frame.
// Configuration writes are taken every cycle. Uses tac_pkg; instantiates
// tac_ctrl and tac_datapath.
module touch_average_calibrate #(
  parameter int unsigned FRAME_LEN = tac_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tac_pkg::in_beat_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tac_pkg::out_beat_t             out_data_o
);

  tac_pkg::ctrl_cmd_t cmd;
  tac_pkg::ctrl_sts_t sts;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  tac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tac_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/tac_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Uses widths from tac_pkg.
module tac_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tac_pkg::PROD_W-1:0]  dividend_i,
  input  logic [tac_pkg::CAL_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [tac_pkg::PROD_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(tac_pkg::PROD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(tac_pkg::PROD_W - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [tac_pkg::CAL_W-1:0]  rem_q, rem_d;
  logic [tac_pkg::PROD_W-1:0] quo_q, quo_d;
  logic [tac_pkg::CAL_W-1:0]  dvs_q, dvs_d;

  logic [tac_pkg::CAL_W:0]    rem_sh;
  logic [tac_pkg::CAL_W:0]    rem_sub;
  logic                       ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[tac_pkg::PROD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = rem_sh >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit in, shift the quotient bit in behind it
      rem_d = ge ? rem_sub[tac_pkg::CAL_W-1:0] : rem_sh[tac_pkg::CAL_W-1:0];
      quo_d = {quo_q[tac_pkg::PROD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/tac_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, per-axis sums and counts, mapping
// arithmetic and output register. Uses tac_pkg and instantiates tac_div.
module tac_datapath #(
  parameter int unsigned FRAME_LEN = tac_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  tac_pkg::in_beat_t              in_data_i,
  input  tac_pkg::ctrl_cmd_t             cmd_i,
  output tac_pkg::ctrl_sts_t             sts_o,
  output tac_pkg::out_beat_t             out_data_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_LEN);

  localparam int unsigned CW = tac_pkg::CAL_W;
  localparam int unsigned SW = tac_pkg::SIZE_W;
  localparam int unsigned OW = tac_pkg::COORD_W;

  // rounded-up reciprocal of the frame length; exact for every 15-bit sum
  localparam int unsigned AVG_SH = tac_pkg::SUM_W + $clog2(FRAME_LEN);
  localparam int unsigned RCP_W  = tac_pkg::SUM_W + 1;
  localparam int unsigned AVG_PW = tac_pkg::SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(FRAME_LEN) - 64'd1) / 64'(FRAME_LEN));

  logic [CW-1:0] cal_left_q, cal_right_q, cal_bottom_q, cal_top_q;
  logic [SW-1:0] width_q, height_q;

  logic [tac_pkg::SUM_W-1:0] sum_h_q, sum_v_q;
  logic [CNT_W-1:0]          cnt_h_q, cnt_v_q;

  logic [CW-1:0]              avg_q;
  logic [tac_pkg::PROD_W-1:0] prod_q;
  logic [CW-1:0]              span_q;
  logic                       neg_q, mirror_q, equal_q;
  logic [OW-1:0]              x_q, y_q;
  logic                       err_q;
  tac_pkg::out_beat_t         out_q;

  logic [CW-1:0] lo, hi, mn, mx;
  logic [SW-1:0] size;
  logic          mirror;
  logic [CW:0]   diff;
  logic [CW-1:0] mag;

  logic [tac_pkg::SUM_W-1:0] sum_sel;
  logic [AVG_PW-1:0]         avg_prod;

  logic                       div_done;
  logic [tac_pkg::PROD_W-1:0] div_quo;

  logic [OW-1:0] q16, coord;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_left_q   <= tac_pkg::CAL_LEFT_RST;
      cal_right_q  <= tac_pkg::CAL_RIGHT_RST;
      cal_bottom_q <= tac_pkg::CAL_BOTTOM_RST;
      cal_top_q    <= tac_pkg::CAL_TOP_RST;
      width_q      <= tac_pkg::WIDTH_RST;
      height_q     <= tac_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tac_pkg::CFG_CAL_LEFT:   cal_left_q   <= cfg_data_i[CW-1:0];
        tac_pkg::CFG_CAL_RIGHT:  cal_right_q  <= cfg_data_i[CW-1:0];
        tac_pkg::CFG_CAL_BOTTOM: cal_bottom_q <= cfg_data_i[CW-1:0];
        tac_pkg::CFG_CAL_TOP:    cal_top_q    <= cfg_data_i[CW-1:0];
        tac_pkg::CFG_WIDTH:      width_q      <= cfg_data_i[SW-1:0];
        tac_pkg::CFG_HEIGHT:     height_q     <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // accumulate; drop samples for an axis that already holds a full set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_h_q <= '0;
      sum_v_q <= '0;
      cnt_h_q <= '0;
      cnt_v_q <= '0;
    end else if (cmd_i.out_load) begin
      sum_h_q <= '0;
      sum_v_q <= '0;
      cnt_h_q <= '0;
      cnt_v_q <= '0;
    end else if (cmd_i.accumulate) begin
      if (in_data_i.axis == tac_pkg::AXIS_H) begin
        if (cnt_h_q < FULL) begin
          sum_h_q <= sum_h_q + tac_pkg::SUM_W'(in_data_i.sample);
          cnt_h_q <= cnt_h_q + 1'b1;
        end
      end else begin
        if (cnt_v_q < FULL) begin
          sum_v_q <= sum_v_q + tac_pkg::SUM_W'(in_data_i.sample);
          cnt_v_q <= cnt_v_q + 1'b1;
        end
      end
    end
  end

  // average of the selected axis: multiply by the reciprocal, keep the high bits
  always_comb begin
    sum_sel  = (cmd_i.axis == tac_pkg::AXIS_H) ? sum_h_q : sum_v_q;
    avg_prod = AVG_PW'(sum_sel) * AVG_PW'(AVG_RCP);
  end

  // axis select and order the calibration ends
  always_comb begin
    if (cmd_i.axis == tac_pkg::AXIS_H) begin
      lo   = cal_left_q;
      hi   = cal_right_q;
      size = width_q;
    end else begin
      lo   = cal_bottom_q;
      hi   = cal_top_q;
      size = height_q;
    end
    mirror = lo > hi;
    mn     = mirror ? hi : lo;
    mx     = mirror ? lo : hi;
    diff   = {1'b0, avg_q} - {1'b0, mn};
    mag    = diff[CW] ? CW'(-diff) : diff[CW-1:0];
  end

  // |avg - min| * size / span
  tac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // restore the sign, then mirror; equal ends force zero
  always_comb begin
    q16   = neg_q ? (~div_quo[OW-1:0] + 1'b1) : div_quo[OW-1:0];
    coord = mirror_q ? (OW'(size) - q16) : q16;
    if (equal_q) begin
      coord = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_avg) begin
      avg_q <= avg_prod[AVG_SH +: CW];
    end
    if (cmd_i.mul_en) begin
      prod_q   <= tac_pkg::PROD_W'(mag) * tac_pkg::PROD_W'(size);
      span_q   <= mx - mn;
      neg_q    <= diff[CW];
      mirror_q <= mirror;
      equal_q  <= lo == hi;
    end
    if (cmd_i.lat_coord) begin
      if (cmd_i.axis == tac_pkg::AXIS_H) begin
        x_q   <= coord;
        err_q <= equal_q;
      end else begin
        y_q   <= coord;
        err_q <= err_q | equal_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q.x_coord   <= x_q;
      out_q.y_coord   <= y_q;
      out_q.cal_error <= err_q;
    end
  end

  assign sts_o.frame_full = (cnt_h_q == FULL) && (cnt_v_q == FULL);
  assign sts_o.div_done   = div_done;
  assign out_data_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_h_q <= FULL) && (cnt_v_q <= FULL))
    else $error("sample count past frame size");

  a_clear_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (cnt_h_q == '0) && (cnt_v_q == '0) && (sum_h_q == '0)
                       && (sum_v_q == '0))
    else $error("frame state not cleared after result load");

endmodule

// ===== design/tac_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences averaging, mapping and result hand-off for both axes.
// Uses tac_pkg; drives the datapath through ctrl_cmd_t.
module tac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tac_pkg::ctrl_cmd_t  cmd_o,
  input  tac_pkg::ctrl_sts_t  sts_i
);

  tac_pkg::state_e state_q, state_d;
  logic            axis_q, axis_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      tac_pkg::ST_IDLE: begin
        if (sts_i.frame_full) begin
          state_d = tac_pkg::ST_AVG;
          axis_d  = tac_pkg::AXIS_H;
        end
      end
      tac_pkg::ST_AVG:       state_d = tac_pkg::ST_MUL;
      tac_pkg::ST_MUL:       state_d = tac_pkg::ST_MAP_START;
      tac_pkg::ST_MAP_START: state_d = tac_pkg::ST_MAP_WAIT;
      tac_pkg::ST_MAP_WAIT: begin
        if (sts_i.div_done) begin
          if (axis_q == tac_pkg::AXIS_H) begin
            state_d = tac_pkg::ST_AVG;
            axis_d  = tac_pkg::AXIS_V;
          end else begin
            state_d = tac_pkg::ST_OUT;
          end
        end
      end
      tac_pkg::ST_OUT: begin
        if (slot_free) begin
          state_d = tac_pkg::ST_IDLE;
        end
      end
      default: state_d = tac_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      tac_pkg::ST_IDLE: begin
        in_ready_o       = !sts_i.frame_full;
        cmd_o.accumulate = in_valid_i && !sts_i.frame_full;
      end
      tac_pkg::ST_AVG:       cmd_o.lat_avg   = 1'b1;
      tac_pkg::ST_MUL:       cmd_o.mul_en    = 1'b1;
      tac_pkg::ST_MAP_START: cmd_o.div_start = 1'b1;
      tac_pkg::ST_MAP_WAIT:  cmd_o.lat_coord = sts_i.div_done;
      tac_pkg::ST_OUT:       cmd_o.out_load  = slot_free;
      default: ;
    endcase
  end

  // hold the result until the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tac_pkg::ST_IDLE;
      axis_q      <= tac_pkg::AXIS_H;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == tac_pkg::ST_MAP_WAIT))
    else $error("divider finished outside a wait state");

  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_q || out_ready_i)
    else $error("result load over an untaken beat");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !sts_i.frame_full)
    else $error("sample taken while a full frame waits");

endmodule

// ===== tb/touch_average_calibrate_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for touch_average_calibrate: follows register, sample and result beats.
// It predicts each calibrated coordinate pair and compares it field by field.
// Uses tac_pkg; instantiated by touch_average_calibrate_tb beside the block.
module touch_average_calibrate_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  tac_pkg::in_beat_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  tac_pkg::out_beat_t             out_data_i,
  output int                             mismatches_o,
  output int                             pending_o
);

  localparam int NS = tac_pkg::FRAME_LEN_DEF;

  logic [tac_pkg::CAL_W-1:0]  cal_left, cal_right, cal_bottom, cal_top;
  logic [tac_pkg::SIZE_W-1:0] width_px, height_px;
  logic [tac_pkg::SUM_W-1:0]  sum_h, sum_v;
  int                         count_h, count_v;
  tac_pkg::out_beat_t         coord_q[$];
  int                         mismatches = 0;
  int                         pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Linear map of one average through a calibration pair; reversed pairs mirror.
  function automatic logic [tac_pkg::COORD_W-1:0] map_to_screen(
    input int avg, input int lo, input int hi, input int size, inout logic err);
    int                          mn, mx, q, folded;
    logic                        mirror;
    logic [tac_pkg::COORD_W-1:0] coord;
    if (lo == hi) begin
      err = 1'b1;
      return '0;
    end
    mirror = (lo > hi);
    mn     = mirror ? hi : lo;
    mx     = mirror ? lo : hi;
    q      = ((avg - mn) * size) / (mx - mn);
    coord  = q[tac_pkg::COORD_W-1:0];
    if (mirror) begin
      folded = size - int'($signed(coord));
      coord  = folded[tac_pkg::COORD_W-1:0];
    end
    return coord;
  endfunction

  function automatic void accumulate_sample(input tac_pkg::in_beat_t beat);
    tac_pkg::out_beat_t want;
    logic               err;
    if (beat.axis == tac_pkg::AXIS_H) begin
      // drop samples for an axis that is already full
      if (count_h >= NS) return;
      sum_h = sum_h + tac_pkg::SUM_W'(beat.sample);
      count_h++;
    end else begin
      if (count_v >= NS) return;
      sum_v = sum_v + tac_pkg::SUM_W'(beat.sample);
      count_v++;
    end
    if (count_h < NS || count_v < NS) return;
    err            = 1'b0;
    want.x_coord   = map_to_screen(int'(sum_h / NS), int'(cal_left), int'(cal_right),
                                   int'(width_px), err);
    want.y_coord   = map_to_screen(int'(sum_v / NS), int'(cal_bottom), int'(cal_top),
                                   int'(height_px), err);
    want.cal_error = err;
    coord_q.push_back(want);
    sum_h   = '0;
    sum_v   = '0;
    count_h = 0;
    count_v = 0;
  endfunction

  task automatic check_result(input tac_pkg::out_beat_t got);
    tac_pkg::out_beat_t want;
    if (coord_q.size() == 0) begin
      report_mismatch($sformatf("result beat (%0d, %0d) with none expected",
                                $signed(got.x_coord), $signed(got.y_coord)));
      return;
    end
    want = coord_q.pop_front();
    if (got.x_coord !== want.x_coord)
      report_mismatch($sformatf("x_coord got %0d, expected %0d",
                                $signed(got.x_coord), $signed(want.x_coord)));
    if (got.y_coord !== want.y_coord)
      report_mismatch($sformatf("y_coord got %0d, expected %0d",
                                $signed(got.y_coord), $signed(want.y_coord)));
    if (got.cal_error !== want.cal_error)
      report_mismatch($sformatf("cal_error got %b, expected %b",
                                got.cal_error, want.cal_error));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_left   = tac_pkg::CAL_LEFT_RST;
      cal_right  = tac_pkg::CAL_RIGHT_RST;
      cal_bottom = tac_pkg::CAL_BOTTOM_RST;
      cal_top    = tac_pkg::CAL_TOP_RST;
      width_px   = tac_pkg::WIDTH_RST;
      height_px  = tac_pkg::HEIGHT_RST;
      sum_h      = '0;
      sum_v      = '0;
      count_h    = 0;
      count_v    = 0;
      coord_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (tac_pkg::cfg_reg_e'(cfg_idx_i))
          tac_pkg::CFG_CAL_LEFT:   cal_left   = cfg_data_i[tac_pkg::CAL_W-1:0];
          tac_pkg::CFG_CAL_RIGHT:  cal_right  = cfg_data_i[tac_pkg::CAL_W-1:0];
          tac_pkg::CFG_CAL_BOTTOM: cal_bottom = cfg_data_i[tac_pkg::CAL_W-1:0];
          tac_pkg::CFG_CAL_TOP:    cal_top    = cfg_data_i[tac_pkg::CAL_W-1:0];
          tac_pkg::CFG_WIDTH:      width_px   = cfg_data_i[tac_pkg::SIZE_W-1:0];
          tac_pkg::CFG_HEIGHT:     height_px  = cfg_data_i[tac_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) accumulate_sample(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      pending <= coord_q.size();
    end
  end

endmodule

// ===== tb/touch_average_calibrate_tb.sv =====
`timescale 1ns / 1ps
// Top of the touch_average_calibrate testbench: clock, reset, register writes and
// sample frames under several idle and stall mixes, then the verdict.
// Uses tac_pkg, touch_average_calibrate and touch_average_calibrate_checker.
module touch_average_calibrate_tb;

  localparam int NS            = tac_pkg::FRAME_LEN_DEF;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 150;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  tac_pkg::in_beat_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  tac_pkg::out_beat_t             out_data_o;
  int                             mismatches;
  int                             pending;
  int                             in_idle_pct   = 0;
  int                             out_stall_pct = 0;

  touch_average_calibrate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  touch_average_calibrate_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_sample(input logic ax, input logic [tac_pkg::SAMPLE_W-1:0] value);
    tac_pkg::in_beat_t beat;
    beat.sample = value;
    beat.axis   = ax;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every predicted result beat has been taken.
  task automatic settle(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input tac_pkg::cfg_reg_e idx,
                           input logic [tac_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_calibration(input int phase);
    logic [tac_pkg::CFG_DATA_W-1:0] l, r, b, t, w, h;
    case (phase)
      0: begin
        // widest span, largest screen
        l = 12'd0;    r = 12'd4095; b = 12'd0;    t = 12'd4095;
        w = 12'h7FF;  h = 12'h7FF;
      end
      1: begin
        // equal horizontal ends, fully reversed vertical pair, one-pixel screen
        l = 12'd2048; r = 12'd2048; b = 12'd4095; t = 12'd0;
        w = 12'd1;    h = 12'd1;
      end
      2: begin
        // one-count spans overflow the coordinate width
        l = 12'd0;    r = 12'd1;    b = 12'd4094; t = 12'd4095;
        w = 12'd2047; h = 12'd2047;
      end
      3: begin
        // zero width through the unused top bit, narrow reversed pair, equal vertical ends
        l = 12'd4095; r = 12'd4094; b = 12'd0;    t = 12'd0;
        w = 12'h800;  h = 12'hFFF;
      end
      default: begin
        l = 12'($urandom_range(4095));
        r = ($urandom_range(7) == 0) ? l : 12'($urandom_range(4095));
        b = 12'($urandom_range(4095));
        t = ($urandom_range(7) == 0) ? b : 12'($urandom_range(4095));
        w = 12'($urandom_range(2047, 1));
        h = 12'($urandom_range(2047, 1));
      end
    endcase
    write_reg(tac_pkg::CFG_CAL_LEFT, l);
    write_reg(tac_pkg::CFG_CAL_RIGHT, r);
    write_reg(tac_pkg::CFG_CAL_BOTTOM, b);
    write_reg(tac_pkg::CFG_CAL_TOP, t);
    write_reg(tac_pkg::CFG_WIDTH, w);
    write_reg(tac_pkg::CFG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a cluster around the touch point, with rail values and wide noise.
  function automatic logic [tac_pkg::SAMPLE_W-1:0] pick_sample(
    input logic [tac_pkg::SAMPLE_W-1:0] center);
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = 4095;
      2, 3, 4: v = int'($urandom_range(4095));
      default: v = int'(center) + int'($urandom_range(128)) - 64;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[tac_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic send_frame();
    int                           n_h, n_v;
    logic                         ax;
    logic [tac_pkg::SAMPLE_W-1:0] center;
    n_h    = 0;
    n_v    = 0;
    center = 12'($urandom_range(4095));
    while (n_h < NS || n_v < NS) begin
      if ((n_h == NS || n_v == NS) && $urandom_range(9) == 0) begin
        // extra beat for an axis that is already full
        ax = (n_h == NS) ? tac_pkg::AXIS_H : tac_pkg::AXIS_V;
      end else begin
        if (n_h == NS)      ax = tac_pkg::AXIS_V;
        else if (n_v == NS) ax = tac_pkg::AXIS_H;
        else                ax = 1'($urandom_range(1));
        if (ax == tac_pkg::AXIS_H) n_h++;
        else                       n_v++;
      end
      send_sample(ax, pick_sample(center));
    end
  endtask

  initial begin
    int frames;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: full-scale horizontal, zero vertical, one surplus horizontal
    for (int i = 0; i < NS; i++) send_sample(tac_pkg::AXIS_H, 12'd4095);
    send_sample(tac_pkg::AXIS_H, 12'd4095);
    for (int i = 0; i < NS; i++) send_sample(tac_pkg::AXIS_V, 12'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle(SETTLE_CYCLES);
      load_calibration(p);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 76; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 76; end
        default: begin in_idle_pct = 9; out_stall_pct = 9; end
      endcase
      frames = $urandom_range(4, 3);
      for (int f = 0; f < frames; f++) begin
        send_frame();
        if (f == 0 || $urandom_range(7) == 0) settle(0);
      end
    end

    settle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tac_pkg.sv
design/tac_div.sv
design/tac_datapath.sv
design/tac_ctrl.sv
design/touch_average_calibrate.sv
tb/touch_average_calibrate_checker.sv
tb/touch_average_calibrate_tb.sv
